// ===== rtl/core/sorted_list_table_macros.svh =====
// Assertion macros shared by the sorted list table RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SLT_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("sorted_list_table: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SLT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("sorted_list_table: next-cycle check failed");

`endif

// ===== rtl/core/slt_pkg.sv =====
// Shared types and constants for the sorted list table.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none

package slt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 5;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_SEARCH   = 2'd2,
    CMD_RETRIEVE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_EMPTY    = 3'd1,
    STATUS_BADPOS   = 3'd2,
    STATUS_NOTFOUND = 3'd3,
    STATUS_FULL     = 3'd4
  } status_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic                       do_insert;
    logic                       do_remove;
    logic signed [VALUE_W-1:0]  key;
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/slt_req_if.sv =====
// Request channel of the sorted list table: valid/ready plus operation fields.
// Depends on slt_pkg.
`default_nettype none

interface slt_req_if;
  import slt_pkg::*;

  logic                       valid;
  logic                       ready;
  cmd_t                       cmd;
  logic signed [VALUE_W-1:0]  value;
  logic        [POS_W-1:0]    position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/slt_rsp_if.sv =====
// Response channel of the sorted list table: valid/ready plus result fields.
// Depends on slt_pkg.
`default_nettype none

interface slt_rsp_if;
  import slt_pkg::*;

  logic                       valid;
  logic                       ready;
  status_t                    status;
  logic        [POS_W-1:0]    found_position;
  logic signed [VALUE_W-1:0]  value_out;

  modport source (output valid, output status, output found_position, output value_out,
                  input ready);
  modport sink   (input valid, input status, input found_position, input value_out,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/slt_cell.sv =====
// One slot of the sorted list: holds an entry, compares it against the key
// and shifts with its neighbors on insert/remove. Depends on slt_pkg.
`default_nettype none

module slt_cell #(
  parameter int CAPACITY = slt_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  wire logic                               clk,
  input  wire slt_pkg::ctl_t                      ctl,
  input  wire logic [$clog2(CAPACITY+1)-1:0]      count,
  input  wire logic [$clog2(CAPACITY)-1:0]        sel_idx,
  input  wire logic signed [slt_pkg::VALUE_W-1:0] left_entry,
  input  wire logic                               left_lt,
  input  wire logic                               left_seen,
  input  wire logic signed [slt_pkg::VALUE_W-1:0] right_entry,
  output logic signed [slt_pkg::VALUE_W-1:0]      entry,
  output logic                                    lt,
  output logic                                    seen,
  output logic                                    hit_first,
  output logic                                    sel_hit
);
  import slt_pkg::*;

  localparam int CW = $clog2(CAPACITY+1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_I = IW'(IDX);

  logic live;
  logic match;

  assign live      = IDX_C < count;
  assign lt        = live && ($signed(entry) < $signed(ctl.key));
  assign match     = live && (entry == ctl.key);
  assign seen      = left_seen | match;
  assign hit_first = match & ~left_seen;
  assign sel_hit   = (IDX_I == sel_idx);

  // lt is a prefix over the sorted row: the first cell without lt takes
  // the key, cells after it take their left neighbor.
  always_ff @(posedge clk) begin
    if (ctl.do_insert) begin
      if (!lt) begin
        entry <= left_lt ? ctl.key : left_entry;
      end
    end else if (ctl.do_remove) begin
      if (IDX_I >= sel_idx) begin
        entry <= right_entry;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_list_table.sv =====
// Sorted list table: keeps up to CAPACITY signed 32-bit values in ascending
// order and takes one request per clock while the output register is free or
// being taken (insert, remove at position, search, retrieve at position).
// Each request gives exactly one response, held in a single output register
// from the cycle after acceptance; while that register is taken in the same
// cycle, back-to-back requests run at one per cycle. A row of CAPACITY cells
// compares in parallel and shifts into its neighbors; the search first-hit
// flag ripples along the row, which sets the critical path as CAPACITY grows.
`default_nettype none

module sorted_list_table
  import slt_pkg::*;
#(
  parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  slt_req_if.sink   req,
  slt_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY+1);
  localparam int IW = $clog2(CAPACITY);
  localparam int MW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  ctl_t ctl;
  logic accept;
  logic full;
  logic empty;
  logic pos_ok;
  logic [IW-1:0] sel_idx;

  logic signed [VALUE_W-1:0] entry_v [CAPACITY];
  logic [CAPACITY-1:0] lt_v;
  logic [CAPACITY-1:0] seen_v;
  logic [CAPACITY-1:0] hit_v;
  logic [CAPACITY-1:0] sel_v;

  logic [POS_W-1:0]          hit_pos;
  logic signed [VALUE_W-1:0] rd_value;

  status_t                   status_next;
  logic [POS_W-1:0]          fpos_next;
  logic signed [VALUE_W-1:0] vout_next;

  status_t                   out_status;
  logic [POS_W-1:0]          out_fpos;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_valid;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign pos_ok  = (req.position != '0) && (MW'(req.position) <= MW'(count));
  assign sel_idx = IW'(req.position - POS_W'(1));

  assign ctl.do_insert = accept && (req.cmd == CMD_INSERT) && !full;
  assign ctl.do_remove = accept && (req.cmd == CMD_REMOVE) && !empty && pos_ok;
  assign ctl.key       = req.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_entry;
    logic                      left_lt;
    logic                      left_seen;
    logic signed [VALUE_W-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_lt    = 1'b1;
      assign left_seen  = 1'b0;
    end else begin : g_body
      assign left_entry = entry_v[i-1];
      assign left_lt    = lt_v[i-1];
      assign left_seen  = seen_v[i-1];
    end

    if (i == CAPACITY-1) begin : g_tail
      assign right_entry = entry_v[i];
    end else begin : g_mid
      assign right_entry = entry_v[i+1];
    end

    slt_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .sel_idx     (sel_idx),
      .left_entry  (left_entry),
      .left_lt     (left_lt),
      .left_seen   (left_seen),
      .right_entry (right_entry),
      .entry       (entry_v[i]),
      .lt          (lt_v[i]),
      .seen        (seen_v[i]),
      .hit_first   (hit_v[i]),
      .sel_hit     (sel_v[i])
    );
  end

  // At most one hit_first and one sel_hit are set, so OR-merge is enough.
  always_comb begin
    hit_pos  = '0;
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_v[i]) hit_pos = hit_pos | POS_W'(i + 1);
      if (sel_v[i]) rd_value = rd_value | entry_v[i];
    end
  end

  always_comb begin
    status_next = STATUS_OK;
    fpos_next   = '0;
    vout_next   = '0;
    unique case (req.cmd) inside
      CMD_INSERT: begin
        if (full) status_next = STATUS_FULL;
      end
      CMD_SEARCH: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else if (seen_v[CAPACITY-1]) begin
          fpos_next = hit_pos;
        end else begin
          status_next = STATUS_NOTFOUND;
        end
      end
      CMD_REMOVE, CMD_RETRIEVE: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else if (!pos_ok) begin
          status_next = STATUS_BADPOS;
        end else begin
          vout_next = rd_value;
        end
      end
      default: status_next = STATUS_OK;
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctl.do_insert) count_next = count + CW'(1);
    else if (ctl.do_remove) count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_fpos   <= fpos_next;
      out_value  <= vout_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.found_position = out_fpos;
  assign rsp.value_out      = out_value;

`include "sorted_list_table_macros.svh"

  `SLT_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `SLT_ASSERT_NEXT(a_insert_grows, clk, rst, ctl.do_insert, count == $past(count) + CW'(1))
  `SLT_ASSERT_NEXT(a_accept_resp, clk, rst, accept, out_valid)
  `SLT_ASSERT_IMPL(a_err_no_value, clk, rst, out_valid && (out_status != STATUS_OK), (out_value == '0) && (out_fpos == '0))

endmodule

`default_nettype wire
